[hw/rtl/efip_pkg.sv]
// Package for the encapsulated fragment item parser.
// Holds parse phase codes, result kind codes, item tags and the result word type.
// No dependencies.
package efip_pkg;

  // Parse phases.
  localparam logic [2:0] PH_DONE   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_TAG    = 3'd2;
  localparam logic [2:0] PH_LENGTH = 3'd3;
  localparam logic [2:0] PH_SKIP   = 3'd4;

  // Result kinds.
  localparam logic [2:0] K_FRAME   = 3'd0;
  localparam logic [2:0] K_DELIM   = 3'd1;
  localparam logic [2:0] K_END     = 3'd2;
  localparam logic [2:0] K_OVERRUN = 3'd3;
  localparam logic [2:0] K_BADTAG  = 3'd4;
  localparam logic [2:0] K_TRUNC   = 3'd5;

  // Item tags and the offset-table header length.
  localparam logic [31:0] ITEM_TAG     = 32'hfffe_e000;
  localparam logic [31:0] DELIM_TAG    = 32'hfffe_e0dd;
  localparam logic [31:0] HEADER_BYTES = 32'd8;

  // Depth of the result buffer; a byte is taken while two slots are free.
  localparam int RES_DEPTH = 4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] frame_start;
    logic [31:0] frame_length;
    logic        last_result;
  } result_t;

  // Bit position of each tag byte: the two 16-bit halves are swapped.
  function automatic logic [4:0] tag_shift(input logic [1:0] idx);
    logic [4:0] pos;
    case (idx)
      2'd0:    pos = 5'd16;
      2'd1:    pos = 5'd24;
      2'd2:    pos = 5'd0;
      default: pos = 5'd8;
    endcase
    return pos;
  endfunction

endpackage

[hw/rtl/efip_if.sv]
// Channel interfaces of the encapsulated fragment item parser.
// Byte input, result output and buffer size write channels; no dependencies.
interface efip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

interface efip_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] frame_start;
  logic [31:0] frame_length;
  logic        last_result;

  modport source (output valid, output kind, output frame_start, output frame_length,
                  output last_result, input ready);
  modport sink (input valid, input kind, input frame_start, input frame_length,
                input last_result, output ready);
endinterface

interface efip_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] buffer_size;

  modport source (output valid, output buffer_size, input ready);
  modport sink (input valid, input buffer_size, output ready);
endinterface

[hw/rtl/encapsulated_fragment_item_parser_unit.sv]
// Top level of the encapsulated fragment item parser.
// Depends on efip_pkg and the channel interfaces in efip_if.sv.
// A result word is written into the result buffer when the byte that causes it is taken.
// Throughput: one byte per cycle; a byte yields up to two words, drained one per cycle
// from a four-word result buffer, and a byte is taken while two buffer slots are free.
// Reset: buffer size is zero, the buffer is empty and the parser waits for a first byte.
module encapsulated_fragment_item_parser_unit (
  input  logic           clk,
  input  logic           rst,
  efip_in_if.sink        byte_ch,
  efip_out_if.source     result,
  efip_cfg_if.sink       cfg
);
  import efip_pkg::*;

  localparam int PTR_W = $clog2(RES_DEPTH);
  localparam int CNT_W = $clog2(RES_DEPTH + 1);

  // Parser state.
  logic [31:0] buffer_size;
  logic [2:0]  phase, phase_next;
  logic [31:0] byte_offset, byte_offset_next;
  logic [31:0] field_shift, field_shift_next;
  logic [1:0]  byte_in_field, byte_in_field_next;
  logic [31:0] skip_remaining, skip_remaining_next;

  // Result buffer.
  result_t          res_q [RES_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] cnt;

  logic    in_acc, out_acc;
  logic [1:0] n_res;
  result_t r0, r1;

  // Step working values.
  logic [2:0]  ph;
  logic [31:0] off, off1, fs, fs1, skip, skip1;
  logic [1:0]  bif, bif1;
  logic        at_end;
  logic [32:0] frame_end;

  assign in_acc  = byte_ch.valid && byte_ch.ready;
  assign out_acc = result.valid && result.ready;

  assign byte_ch.ready = (cnt <= CNT_W'(RES_DEPTH - 2));
  assign cfg.ready     = 1'b1;

  // Buffer size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= '0;
    end else if (cfg.valid && cfg.ready) begin
      buffer_size <= cfg.buffer_size;
    end
  end

  // One parse step per accepted byte.
  always_comb begin
    ph   = byte_ch.first_byte ? PH_HEADER : phase;
    off  = byte_ch.first_byte ? '0 : byte_offset;
    fs   = byte_ch.first_byte ? '0 : field_shift;
    bif  = byte_ch.first_byte ? '0 : byte_in_field;
    skip = byte_ch.first_byte ? '0 : skip_remaining;

    off1      = off + 32'd1;
    at_end    = (off1 == buffer_size);
    bif1      = bif + 2'd1;
    skip1     = skip - 32'd1;
    fs1       = '0;
    frame_end = {1'b0, off1};

    phase_next          = ph;
    byte_offset_next    = off;
    field_shift_next    = fs;
    byte_in_field_next  = bif;
    skip_remaining_next = skip;

    n_res = 2'd0;
    r0    = '{kind: K_END, frame_start: '0, frame_length: '0, last_result: 1'b1};
    r1    = '{kind: K_END, frame_start: '0, frame_length: '0, last_result: 1'b1};

    if (ph == PH_DONE) begin
      n_res = 2'd0;
    end else if (off >= buffer_size) begin
      // Byte past the size: an end at an item boundary, otherwise a cut-off field.
      n_res      = 2'd1;
      r0.kind    = ((ph == PH_HEADER) || (ph == PH_TAG && bif == 2'd0)) ? K_END : K_TRUNC;
      phase_next = PH_DONE;
    end else begin
      byte_offset_next = off1;
      unique case (ph)
        PH_HEADER: begin
          if (at_end) begin
            n_res      = 2'd1;
            phase_next = PH_DONE;
          end else if (off1 == HEADER_BYTES) begin
            phase_next         = PH_TAG;
            byte_in_field_next = '0;
            field_shift_next   = '0;
          end
        end
        PH_TAG: begin
          fs1                = fs | ({24'd0, byte_ch.data_byte} << tag_shift(bif));
          field_shift_next   = fs1;
          byte_in_field_next = bif1;
          if (bif1 != 2'd0) begin
            if (at_end) begin
              n_res      = 2'd1;
              r0.kind    = K_TRUNC;
              phase_next = PH_DONE;
            end
          end else if (fs1 == DELIM_TAG) begin
            n_res      = 2'd1;
            r0.kind    = K_DELIM;
            phase_next = PH_DONE;
          end else if (fs1 != ITEM_TAG) begin
            n_res      = 2'd1;
            r0.kind    = K_BADTAG;
            phase_next = PH_DONE;
          end else if (at_end) begin
            n_res      = 2'd1;
            r0.kind    = K_TRUNC;
            phase_next = PH_DONE;
          end else begin
            phase_next       = PH_LENGTH;
            field_shift_next = '0;
          end
        end
        PH_LENGTH: begin
          fs1                = fs | ({24'd0, byte_ch.data_byte} << {bif, 3'b000});
          field_shift_next   = fs1;
          byte_in_field_next = bif1;
          frame_end          = {1'b0, off1} + {1'b0, fs1};
          if (bif1 != 2'd0) begin
            if (at_end) begin
              n_res      = 2'd1;
              r0.kind    = K_TRUNC;
              phase_next = PH_DONE;
            end
          end else if (frame_end > {1'b0, buffer_size}) begin
            n_res           = 2'd1;
            r0.kind         = K_OVERRUN;
            r0.frame_start  = off1;
            r0.frame_length = fs1;
            phase_next      = PH_DONE;
          end else begin
            n_res           = 2'd1;
            r0.kind         = K_FRAME;
            r0.frame_start  = off1;
            r0.frame_length = fs1;
            if (fs1 == 32'd0) begin
              // Empty frame: straight back to tag reading.
              phase_next         = PH_TAG;
              byte_in_field_next = '0;
              field_shift_next   = '0;
              if (at_end) begin
                n_res          = 2'd2;
                r0.last_result = 1'b0;
                phase_next     = PH_DONE;
              end
            end else begin
              phase_next          = PH_SKIP;
              skip_remaining_next = fs1;
            end
          end
        end
        PH_SKIP: begin
          skip_remaining_next = skip1;
          if (skip1 == 32'd0) begin
            phase_next         = PH_TAG;
            byte_in_field_next = '0;
            field_shift_next   = '0;
            if (at_end) begin
              n_res      = 2'd1;
              phase_next = PH_DONE;
            end
          end
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_DONE;
      byte_offset    <= '0;
      field_shift    <= '0;
      byte_in_field  <= '0;
      skip_remaining <= '0;
    end else if (in_acc) begin
      phase          <= phase_next;
      byte_offset    <= byte_offset_next;
      field_shift    <= field_shift_next;
      byte_in_field  <= byte_in_field_next;
      skip_remaining <= skip_remaining_next;
    end
  end

  // Result buffer storage; entries need no reset.
  always_ff @(posedge clk) begin
    if (in_acc && n_res != 2'd0) begin
      res_q[wr_ptr] <= r0;
      if (n_res == 2'd2) begin
        res_q[wr_ptr + PTR_W'(1)] <= r1;
      end
    end
  end

  // Result buffer pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr <= wr_ptr + PTR_W'(n_res);
      end
      if (out_acc) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      cnt <= cnt + (in_acc ? CNT_W'(n_res) : CNT_W'(0)) - (out_acc ? CNT_W'(1) : CNT_W'(0));
    end
  end

  // Output word.
  assign result.valid        = (cnt != '0);
  assign result.kind         = res_q[rd_ptr].kind;
  assign result.frame_start  = res_q[rd_ptr].frame_start;
  assign result.frame_length = res_q[rd_ptr].frame_length;
  assign result.last_result  = res_q[rd_ptr].last_result;

  // The result buffer never holds more words than it has slots.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(RES_DEPTH))
    else $error("result buffer overflow");

  // Any result other than a found frame ends the parse.
  a_end_stops: assert property (@(posedge clk) disable iff (rst)
    (in_acc && n_res == 2'd1 && r0.kind != K_FRAME) |=> (phase == PH_DONE))
    else $error("parser still running after an end result");

  // Two words from one byte are always an empty frame followed by an end of buffer.
  a_pair_form: assert property (@(posedge clk) disable iff (rst)
    (in_acc && n_res == 2'd2) |-> (r0.kind == K_FRAME && r1.kind == K_END
                                   && r0.frame_length == 32'd0))
    else $error("unexpected pair of results");

endmodule

[tb/encapsulated_fragment_item_parser_unit_tb.sv]
// Testbench for encapsulated_fragment_item_parser_unit: feeds byte streams of fragment items and
// checks every result word against a cycle-free predictor kept in this file.
// Depends on efip_pkg and the channel interfaces in efip_if.sv.
module encapsulated_fragment_item_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import efip_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TOTAL_BYTES    = 1550;
  localparam int MAX_REPORTS    = 100;

  logic clk;
  logic rst;

  efip_in_if  byte_if ();
  efip_out_if res_if ();
  efip_cfg_if cfg_if ();

  encapsulated_fragment_item_parser_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .byte_ch(byte_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  // Parser state as the block should hold it, plus the size register.
  logic [2:0]  parse_phase  = PH_DONE;
  logic [31:0] parse_offset = '0;
  logic [31:0] field_word   = '0;
  logic [1:0]  field_count  = '0;
  logic [31:0] frame_len    = '0;
  logic [31:0] skip_left    = '0;
  logic [31:0] size_setting = '0;

  result_t     expected_results [$];
  logic [7:0]  buf_bytes [$];
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent     = 0;
  int unsigned rx_hold_cycles = 0;
  bit          tx_steady      = 1'b0;
  bit          rx_steady      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    // Keep the log short when the block is badly broken.
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------

  task automatic add_result(input logic [2:0] result_kind, input logic [31:0] start,
                            input logic [31:0] len);
    result_t word;
    word.kind         = result_kind;
    word.frame_start  = start;
    word.frame_length = len;
    word.last_result  = 1'b0;
    expected_results = {expected_results, word};
  endtask

  task automatic finish_parse(input logic [2:0] result_kind);
    add_result(result_kind, '0, '0);
    parse_phase = PH_DONE;
  endtask

  task automatic open_tag_field();
    parse_phase = PH_TAG;
    field_count = '0;
    field_word  = '0;
  endtask

  // Works out the result words that one accepted byte causes.
  task automatic predict_byte(input logic [7:0] b, input logic first);
    int unsigned queued;
    queued = expected_results.size();
    if (first) begin
      parse_phase  = PH_HEADER;
      parse_offset = '0;
      field_word   = '0;
      field_count  = '0;
      frame_len    = '0;
      skip_left    = '0;
    end
    if (parse_phase != PH_DONE) begin
      if (parse_offset >= size_setting) begin
        // The byte lies past the buffer: an end at an item boundary, a cut-off otherwise.
        if (parse_phase == PH_HEADER || (parse_phase == PH_TAG && field_count == 2'd0)) begin
          finish_parse(K_END);
        end else begin
          finish_parse(K_TRUNC);
        end
      end else begin
        parse_offset = parse_offset + 32'd1;
        case (parse_phase)
          PH_HEADER: begin
            if (parse_offset == size_setting) begin
              finish_parse(K_END);
            end else if (parse_offset == HEADER_BYTES) begin
              open_tag_field();
            end
          end
          PH_TAG: begin
            // Tag bytes land in bits 23:16, 31:24, 7:0 and 15:8 in turn.
            case (field_count)
              2'd0:    field_word[23:16] = b;
              2'd1:    field_word[31:24] = b;
              2'd2:    field_word[7:0]   = b;
              default: field_word[15:8]  = b;
            endcase
            field_count = field_count + 2'd1;
            if (field_count != 2'd0) begin
              if (parse_offset == size_setting) finish_parse(K_TRUNC);
            end else if (field_word == DELIM_TAG) begin
              finish_parse(K_DELIM);
            end else if (field_word != ITEM_TAG) begin
              finish_parse(K_BADTAG);
            end else if (parse_offset == size_setting) begin
              finish_parse(K_TRUNC);
            end else begin
              parse_phase = PH_LENGTH;
              field_word  = '0;
            end
          end
          PH_LENGTH: begin
            field_word[field_count * 8 +: 8] = b;
            field_count = field_count + 2'd1;
            if (field_count != 2'd0) begin
              if (parse_offset == size_setting) finish_parse(K_TRUNC);
            end else begin
              frame_len = field_word;
              // Frame end is compared one bit wider so that it cannot wrap.
              if ({1'b0, parse_offset} + {1'b0, frame_len} > {1'b0, size_setting}) begin
                add_result(K_OVERRUN, parse_offset, frame_len);
                parse_phase = PH_DONE;
              end else begin
                add_result(K_FRAME, parse_offset, frame_len);
                if (frame_len == '0) begin
                  open_tag_field();
                  if (parse_offset == size_setting) finish_parse(K_END);
                end else begin
                  parse_phase = PH_SKIP;
                  skip_left   = frame_len;
                end
              end
            end
          end
          PH_SKIP: begin
            skip_left = skip_left - 32'd1;
            if (skip_left == '0) begin
              open_tag_field();
              if (parse_offset == size_setting) finish_parse(K_END);
            end
          end
          default: parse_phase = PH_DONE;
        endcase
      end
    end
    if (expected_results.size() > queued) begin
      expected_results[expected_results.size() - 1].last_result = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------------------

  // Offers one byte word after a random gap and predicts its results once it is taken.
  task automatic send_byte(input logic [7:0] b, input logic first);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 10);
    if ($urandom_range(0, 63) == 0) tx_steady = !tx_steady;
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_if.valid      <= 1'b1;
    byte_if.data_byte  <= b;
    byte_if.first_byte <= first;
    do @(posedge clk); while (!byte_if.ready);
    bytes_sent++;
    predict_byte(b, first);
  endtask

  // Stops offering bytes and waits until every expected word has come out.
  task automatic wait_for_results();
    byte_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(input logic [31:0] value);
    wait_for_results();
    cfg_if.valid       <= 1'b1;
    cfg_if.buffer_size <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    size_setting = value;
  endtask

  // ---------------------------------------------------------------------------------------
  // Buffer building
  // ---------------------------------------------------------------------------------------

  task automatic append_byte(input logic [7:0] b);
    buf_bytes = {buf_bytes, b};
  endtask

  task automatic begin_buffer();
    buf_bytes.delete();
    repeat (HEADER_BYTES) append_byte(8'($urandom));
  endtask

  task automatic push_tag(input logic [31:0] tag);
    append_byte(tag[23:16]);
    append_byte(tag[31:24]);
    append_byte(tag[7:0]);
    append_byte(tag[15:8]);
  endtask

  task automatic push_length(input logic [31:0] len);
    for (int i = 0; i < 4; i++) append_byte(len[i * 8 +: 8]);
  endtask

  task automatic push_random_data(input int count);
    repeat (count) append_byte(8'($urandom));
  endtask

  // Sends bytes from..to-1 of the buffer; byte zero carries the first-byte mark.
  task automatic send_buffer_range(input int from, input int to);
    for (int i = from; i < to && i < buf_bytes.size(); i++) send_byte(buf_bytes[i], i == 0);
  endtask

  task automatic build_random_buffer();
    int item_total;
    int len;
    int pick;
    begin_buffer();
    item_total = $urandom_range(0, 5);
    repeat (item_total) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        push_tag($urandom);
      end else if (pick == 1) begin
        push_tag(ITEM_TAG ^ (32'd1 << $urandom_range(0, 31)));
      end else begin
        push_tag(ITEM_TAG);
      end
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        // A length this large almost always runs past the buffer.
        push_length($urandom);
      end else begin
        len = (pick < 3) ? $urandom_range(13, 60) : $urandom_range(0, 12);
        push_length(len);
        push_random_data(len);
      end
    end
    pick = $urandom_range(0, 5);
    if (pick < 3) begin
      push_tag(DELIM_TAG);
    end else if (pick == 3) begin
      push_tag($urandom);
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Sizes of zero, inside the header and exactly the header.
  task automatic test_size_extremes();
    write_size('0);
    begin_buffer();
    send_buffer_range(0, 2);
    write_size(32'd5);
    send_buffer_range(0, 6);
    write_size(HEADER_BYTES);
    send_buffer_range(0, 8);
  endtask

  task automatic test_frame_and_delimiter();
    write_size(32'hFFFF_FFFF);
    begin_buffer();
    push_tag(ITEM_TAG);
    push_length(32'd2);
    append_byte(8'h00);
    append_byte(8'hFF);
    push_tag(ITEM_TAG);
    push_length(32'd5);
    push_random_data(5);
    push_tag(DELIM_TAG);
    send_buffer_range(0, buf_bytes.size());
  endtask

  // An empty frame that ends the buffer, then a frame whose data ends it.
  task automatic test_frame_at_buffer_end();
    write_size(32'd16);
    begin_buffer();
    push_tag(ITEM_TAG);
    push_length('0);
    send_buffer_range(0, buf_bytes.size());
    write_size(32'd18);
    begin_buffer();
    push_tag(ITEM_TAG);
    push_length(32'd2);
    push_random_data(2);
    push_tag(DELIM_TAG);
    send_buffer_range(0, buf_bytes.size());
  endtask

  task automatic test_overrun();
    write_size(32'hFFFF_FFFF);
    begin_buffer();
    push_tag(ITEM_TAG);
    push_length(32'hFFFF_FFFF);
    send_buffer_range(0, buf_bytes.size());
    write_size(32'd20);
    begin_buffer();
    push_tag(ITEM_TAG);
    push_length(32'd5);
    push_random_data(5);
    send_buffer_range(0, buf_bytes.size());
  endtask

  task automatic test_bad_tag();
    write_size(32'hFFFF_FFFF);
    begin_buffer();
    push_tag(ITEM_TAG ^ 32'h0001_0000);
    send_buffer_range(0, buf_bytes.size());
    begin_buffer();
    push_tag('0);
    send_buffer_range(0, buf_bytes.size());
  endtask

  // The size ends the buffer inside a tag, right after an item tag, and inside a length.
  task automatic test_truncation();
    int cut_sizes [3] = '{10, 12, 14};
    foreach (cut_sizes[i]) begin
      write_size(cut_sizes[i]);
      begin_buffer();
      push_tag(ITEM_TAG);
      push_length(32'd4);
      push_random_data(4);
      send_buffer_range(0, buf_bytes.size());
    end
  endtask

  // The size drops below the byte count while a parse is in progress.
  task automatic test_size_lowered_mid_parse();
    write_size(32'd100);
    begin_buffer();
    push_tag(ITEM_TAG);
    push_length(32'd8);
    push_random_data(8);
    send_buffer_range(0, 10);
    write_size(32'd4);
    send_buffer_range(10, 11);
    write_size(32'd100);
    send_buffer_range(0, 3);
    write_size(32'd2);
    send_buffer_range(3, 4);
    write_size(32'd100);
    send_buffer_range(0, 19);
    write_size(32'd10);
    send_buffer_range(19, 20);
  endtask

  // A first byte in the middle of a length restarts the parser.
  task automatic test_restart_mid_parse();
    write_size(32'hFFFF_FFFF);
    begin_buffer();
    push_tag(ITEM_TAG);
    push_length(32'd3);
    push_random_data(3);
    push_tag(DELIM_TAG);
    send_buffer_range(0, 14);
    send_buffer_range(0, buf_bytes.size());
  endtask

  // The receiver holds off while a run of empty frames fills the result buffer.
  task automatic test_result_backpressure();
    write_size(32'hFFFF_FFFF);
    begin_buffer();
    repeat (30) begin
      push_tag(ITEM_TAG);
      push_length('0);
    end
    push_tag(DELIM_TAG);
    rx_hold_cycles = 300;
    send_buffer_range(0, buf_bytes.size());
    wait_for_results();
  endtask

  // Random buffers until the whole run has sent its share of bytes.
  task automatic test_random_buffers();
    int pick;
    int cut;
    while (bytes_sent < TOTAL_BYTES) begin
      if ($urandom_range(0, 9) == 0) begin
        // Stray bytes, now and then with a first-byte mark.
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(0, 15) == 0);
      end else begin
        build_random_buffer();
        pick = $urandom_range(0, 15);
        case (pick)
          0:       write_size($urandom_range(0, 8));
          1, 2:    write_size(buf_bytes.size());
          3:       write_size(buf_bytes.size() - $urandom_range(1, 6));
          4:       write_size($urandom_range(9, 80));
          5:       write_size(32'hFFFF_FFFF);
          6:       write_size($urandom);
          default: ;
        endcase
        pick = $urandom_range(0, 11);
        if (pick == 0) begin
          cut = $urandom_range(1, buf_bytes.size() - 1);
          send_buffer_range(0, cut);
          write_size($urandom_range(0, cut + 2));
          send_buffer_range(cut, buf_bytes.size());
        end else if (pick < 3) begin
          send_buffer_range(0, $urandom_range(1, buf_bytes.size()));
        end else begin
          send_buffer_range(0, buf_bytes.size());
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------------------

  // Takes each result word after a random stall and compares it with the oldest expectation.
  initial begin : result_checker
    int      stall;
    result_t got;
    result_t want;
    res_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = rx_steady ? 0 : $urandom_range(0, 10);
      end
      if ($urandom_range(0, 63) == 0) rx_steady = !rx_steady;
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      got.kind         = res_if.kind;
      got.frame_start  = res_if.frame_start;
      got.frame_length = res_if.frame_length;
      got.last_result  = res_if.last_result;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected word: kind %0d start %0d length %0d last %0b",
                                  got.kind, got.frame_start, got.frame_length,
                                  got.last_result));
      end else begin
        want = expected_results.pop_front();
        if (got.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
        if (got.frame_start !== want.frame_start)
          report_mismatch($sformatf("frame_start %0d, expected %0d",
                                    got.frame_start, want.frame_start));
        if (got.frame_length !== want.frame_length)
          report_mismatch($sformatf("frame_length %0d, expected %0d",
                                    got.frame_length, want.frame_length));
        if (got.last_result !== want.last_result)
          report_mismatch($sformatf("last_result %0b, expected %0b",
                                    got.last_result, want.last_result));
      end
    end
  end

  // Ends the run when no word moves on any channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    rst                <= 1'b1;
    byte_if.valid      <= 1'b0;
    byte_if.data_byte  <= '0;
    byte_if.first_byte <= 1'b0;
    cfg_if.valid       <= 1'b0;
    cfg_if.buffer_size <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_size_extremes();
    test_frame_and_delimiter();
    test_frame_at_buffer_end();
    test_overrun();
    test_bad_tag();
    test_truncation();
    test_size_lowered_mid_parse();
    test_restart_mid_parse();
    test_result_backpressure();
    test_random_buffers();

    wait_for_results();
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/efip_pkg.sv
hw/rtl/efip_if.sv
hw/rtl/encapsulated_fragment_item_parser_unit.sv
tb/encapsulated_fragment_item_parser_unit_tb.sv
